@@ design/dpc_pkg.sv @@
package dpc_pkg;

  // Fixed point: positions in units of 2^-FRAC_BITS mm
  localparam int FRAC_BITS   = 8;
  localparam int SCALE_SHIFT = 16 - FRAC_BITS;

  // APB address width: six 32-bit registers at 4*i
  localparam int ADDR_W = 5;

  // Working width after the rotation stage and output width
  localparam int WORK_W = 22;
  localparam int OUT_W  = 18;

  // Stage-2 clamp limit and rotation constants (rotation constants Q2.30)
  localparam longint WORK_LIM  = 64'sd2147483647;
  localparam longint ROT_COS   = 64'sd1073733234;
  localparam longint ROT_SIN   = 64'sd4294956;
  localparam int     ROT_SHIFT = 30;

  // Saturation after rotation; far enough out that any value beyond it still
  // saturates the output after the later (monotonic) stages
  localparam int SAT_LIM = 524287;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Pipeline depths
  localparam int FRONT_DEPTH = 4;
  localparam int SEG_DEPTH   = 5;

  // Segment map datapath widths
  localparam int MAX_BRK     = 15;
  localparam int SEG_IDX_W   = 4;
  localparam int MUL_W       = 12;
  localparam int DIV_W       = 12;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 32;
  localparam int M_W         = 32;
  localparam int Q_W         = 24;

  // Calibration levels
  localparam logic [2:0] LVL_ROTATE   = 3'd1;
  localparam logic [2:0] LVL_SLIDE    = 3'd2;
  localparam logic [2:0] LVL_COARSE   = 3'd3;
  localparam logic [2:0] LVL_FINE     = 3'd4;
  localparam logic [2:0] LVL_STRETCH  = 3'd5;
  localparam logic [2:0] LVL_MISMATCH = 3'd6;

  typedef struct packed {
    logic [2:0]         corr_lvl;
    logic               alt_geometry;
    logic signed [15:0] x_ctr;
    logic signed [15:0] z_ctr;
    logic [15:0]        x_gain;
    logic [15:0]        z_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    corr_lvl:     3'd0,
    alt_geometry: 1'b0,
    x_ctr:        16'sd2227,
    z_ctr:        -16'sd11213,
    x_gain:       16'd3447,
    z_gain:       16'd3296
  };

  typedef enum logic [2:0] {
    REG_CAL_LEVEL,
    REG_ALT_GEOMETRY,
    REG_X_OFFSET,
    REG_Z_OFFSET,
    REG_X_GAIN,
    REG_Z_GAIN
  } reg_e;

  typedef enum logic [2:0] {
    MAP_COARSE_X,
    MAP_COARSE_Z,
    MAP_FINE_X,
    MAP_FINE_Z,
    MAP_STRETCH_X,
    MAP_STRETCH_Z
  } map_e;

  // Breakpoints and targets in 1/100 mm
  localparam int COARSE_X_BRK [4] = '{-3500, -905, 1127, 3500};
  localparam int COARSE_Z_BRK [4] = '{-3500, -861, 1187, 3500};
  localparam int COARSE_TGT   [4] = '{-3500, -1000, 1000, 3500};
  localparam int FINE_X_BRK  [15] = '{-3500, -3038, -2530, -2020, -1505, -1000, -476, 13,
                                       538, 1000, 1522, 2002, 2485, 3003, 3500};
  localparam int FINE_Z_BRK  [15] = '{-3500, -3008, -2507, -2008, -1512, -1000, -490, 15,
                                       508, 1000, 1501, 1983, 2461, 2968, 3500};
  localparam int FINE_TGT    [15] = '{-3500, -3000, -2500, -2000, -1500, -1000, -500, 0,
                                       500, 1000, 1500, 2000, 2500, 3000, 3500};

  // 1/100 mm to position units, rounded to nearest, ties away from zero
  function automatic int hq(input int h);
    int n;
    n = h * (1 << FRAC_BITS);
    if (n >= 0) return (n + 50) / 100;
    return -((-n + 50) / 100);
  endfunction

  localparam int EDGE       = hq(3500);
  localparam int SLIDE_X    = hq(91);
  localparam int SLIDE_Z    = hq(64);
  localparam int MISMATCH_X = (661175 * (1 << FRAC_BITS) + 1000000) / 2000000;
  localparam int MISMATCH_Z = (246667 * (1 << FRAC_BITS) + 1000000) / 2000000;

  function automatic bit is_stretch(input map_e m);
    return (m == MAP_STRETCH_X) || (m == MAP_STRETCH_Z);
  endfunction

  function automatic bit lower_closed(input map_e m);
    return m == MAP_FINE_Z;
  endfunction

  function automatic int nbrk(input map_e m);
    case (m)
      MAP_COARSE_X, MAP_COARSE_Z: return 4;
      MAP_FINE_X, MAP_FINE_Z:     return 15;
      default:                    return 2;
    endcase
  endfunction

  function automatic int brk(input map_e m, input int j);
    if (j < 0 || j >= nbrk(m)) return 0;
    case (m)
      MAP_COARSE_X: return COARSE_X_BRK[j];
      MAP_COARSE_Z: return COARSE_Z_BRK[j];
      MAP_FINE_X:   return FINE_X_BRK[j];
      MAP_FINE_Z:   return FINE_Z_BRK[j];
      default:      return 0;
    endcase
  endfunction

  function automatic int tgt(input map_e m, input int j);
    if (j < 0 || j >= nbrk(m)) return 0;
    case (m)
      MAP_COARSE_X, MAP_COARSE_Z: return COARSE_TGT[j];
      MAP_FINE_X, MAP_FINE_Z:     return FINE_TGT[j];
      default:                    return 0;
    endcase
  endfunction

  // Segment start in position units (stretch: low and high edge)
  function automatic int seg_start(input map_e m, input int i);
    if (is_stretch(m)) return (i == 0) ? -EDGE : EDGE;
    return hq(brk(m, i));
  endfunction

  // Segment output base in position units
  function automatic int seg_base(input map_e m, input int i);
    if (is_stretch(m)) return (i == 0) ? -EDGE : EDGE;
    return hq(tgt(m, i));
  endfunction

  function automatic int seg_mul(input map_e m, input int i);
    if (is_stretch(m)) return 500;
    if (i + 1 < nbrk(m)) return tgt(m, i + 1) - tgt(m, i);
    return 0;
  endfunction

  function automatic int seg_div(input map_e m, input int i);
    case (m)
      MAP_STRETCH_X: return (i == 0) ? 477 : 462;
      MAP_STRETCH_Z: return (i == 0) ? 524 : 488;
      default: begin
        if (i + 1 < nbrk(m)) return brk(m, i + 1) - brk(m, i);
        return 1;
      end
    endcase
  endfunction

endpackage

@@ design/dpc_in_if.sv @@
interface dpc_in_if #(
  parameter int COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] x_first_time;
  logic [COUNT_BITS-1:0] x_second_time;
  logic [COUNT_BITS-1:0] z_first_time;
  logic [COUNT_BITS-1:0] z_second_time;

  modport source (
    output valid, x_first_time, x_second_time, z_first_time, z_second_time,
    input  ready
  );
  modport sink (
    input  valid, x_first_time, x_second_time, z_first_time, z_second_time,
    output ready
  );
endinterface

@@ design/dpc_out_if.sv @@
interface dpc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dpc_pkg::OUT_W-1:0]  x_position;
  logic signed [dpc_pkg::OUT_W-1:0]  z_position;
  logic                              clipped;

  modport source (
    output valid, x_position, z_position, clipped,
    input  ready
  );
  modport sink (
    input  valid, x_position, z_position, clipped,
    output ready
  );
endinterface

@@ design/dpc_regs.sv @@
module dpc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dpc_pkg::cfg_t               cfg_o
);

  dpc_pkg::cfg_t cfg_q;
  dpc_pkg::reg_e idx;
  logic          wr;

  assign idx    = dpc_pkg::reg_e'(paddr[dpc_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dpc_pkg::CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        dpc_pkg::REG_CAL_LEVEL:    cfg_q.corr_lvl     <= pwdata[2:0];
        dpc_pkg::REG_ALT_GEOMETRY: cfg_q.alt_geometry <= pwdata[0];
        dpc_pkg::REG_X_OFFSET:     cfg_q.x_ctr        <= $signed(pwdata[15:0]);
        dpc_pkg::REG_Z_OFFSET:     cfg_q.z_ctr        <= $signed(pwdata[15:0]);
        dpc_pkg::REG_X_GAIN:       cfg_q.x_gain       <= pwdata[15:0];
        dpc_pkg::REG_Z_GAIN:       cfg_q.z_gain       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      dpc_pkg::REG_CAL_LEVEL:    prdata = {29'd0, cfg_q.corr_lvl};
      dpc_pkg::REG_ALT_GEOMETRY: prdata = {31'd0, cfg_q.alt_geometry};
      dpc_pkg::REG_X_OFFSET:     prdata = 32'(cfg_q.x_ctr);
      dpc_pkg::REG_Z_OFFSET:     prdata = 32'(cfg_q.z_ctr);
      dpc_pkg::REG_X_GAIN:       prdata = {16'd0, cfg_q.x_gain};
      dpc_pkg::REG_Z_GAIN:       prdata = {16'd0, cfg_q.z_gain};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

@@ design/dpc_front.sv @@
module dpc_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  dpc_pkg::cfg_t                      cfg_i,
  input  logic [COUNT_BITS-1:0]              x_first_i,
  input  logic [COUNT_BITS-1:0]              x_second_i,
  input  logic [COUNT_BITS-1:0]              z_first_i,
  input  logic [COUNT_BITS-1:0]              z_second_i,
  output logic signed [dpc_pkg::WORK_W-1:0]  x_o,
  output logic signed [dpc_pkg::WORK_W-1:0]  z_o,
  output logic                               clip_o
);

  localparam int PW = COUNT_BITS + 18;
  localparam int SW = (PW + 1 > 33) ? PW + 1 : 33;
  localparam int SH = dpc_pkg::SCALE_SHIFT;
  localparam int RW = 37;
  localparam int W  = dpc_pkg::WORK_W;

  localparam logic signed [SW-1:0] LIM   = SW'(dpc_pkg::WORK_LIM);
  localparam logic signed [31:0]   COS32 = 32'(dpc_pkg::ROT_COS);
  localparam logic signed [31:0]   SIN32 = 32'(dpc_pkg::ROT_SIN);
  localparam logic signed [RW-1:0] SAT   = RW'(dpc_pkg::SAT_LIM);

  // Round p / 2^SH to nearest, ties away from zero
  function automatic logic signed [SW-1:0] scale_round(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] rnd;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    rnd = (mag + PW'(1 << (SH - 1))) >> SH;
    return p[PW-1] ? -$signed(SW'(rnd)) : $signed(SW'(rnd));
  endfunction

  // Round s / 2^30 to nearest, ties away from zero
  function automatic logic signed [RW-1:0] rot_round(input logic signed [64:0] s);
    logic [64:0] mag;
    logic [64:0] rnd;
    mag = s[64] ? 65'(-s) : 65'(s);
    rnd = (mag + (65'd1 << (dpc_pkg::ROT_SHIFT - 1))) >> dpc_pkg::ROT_SHIFT;
    return s[64] ? -$signed(RW'(rnd)) : $signed(RW'(rnd));
  endfunction

  // Stage 1: count differences times gain
  logic signed [COUNT_BITS:0] dx, dz;
  logic signed [PW-1:0]       px_d, pz_d, px_q, pz_q;

  assign dx   = $signed({1'b0, x_first_i}) - $signed({1'b0, x_second_i});
  assign dz   = $signed({1'b0, z_first_i}) - $signed({1'b0, z_second_i});
  assign px_d = dx * $signed({1'b0, cfg_i.x_gain});
  assign pz_d = dz * $signed({1'b0, cfg_i.z_gain});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
      pz_q <= pz_d;
    end
  end

  // Stage 2: round, subtract offset, clamp to the working limit
  logic signed [SW-1:0] xs, zs;
  logic signed [31:0]   x2_d, z2_d, x2_q, z2_q;
  logic                 clip2_d, clip2_q;

  always_comb begin
    xs      = scale_round(px_q) - SW'(cfg_i.x_ctr);
    zs      = scale_round(pz_q) - SW'(cfg_i.z_ctr);
    clip2_d = 1'b0;
    if (xs > LIM) begin
      x2_d    = 32'(LIM);
      clip2_d = 1'b1;
    end else if (xs < -LIM) begin
      x2_d    = 32'(-LIM);
      clip2_d = 1'b1;
    end else begin
      x2_d = 32'(xs);
    end
    if (zs > LIM) begin
      z2_d    = 32'(LIM);
      clip2_d = 1'b1;
    end else if (zs < -LIM) begin
      z2_d    = 32'(-LIM);
      clip2_d = 1'b1;
    end else begin
      z2_d = 32'(zs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q    <= x2_d;
      z2_q    <= z2_d;
      clip2_q <= clip2_d;
    end
  end

  // Stage 3: rotation products
  logic signed [63:0] xc_q, zs_q, xsn_q, zc_q;
  logic signed [31:0] x3_q, z3_q;
  logic               clip3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xc_q    <= x2_q * COS32;
      zs_q    <= z2_q * SIN32;
      xsn_q   <= x2_q * SIN32;
      zc_q    <= z2_q * COS32;
      x3_q    <= x2_q;
      z3_q    <= z2_q;
      clip3_q <= clip2_q;
    end
  end

  // Stage 4: rotation sums, slide, saturate to the working range
  logic signed [64:0]   nx, nz;
  logic signed [RW-1:0] xr, zr;
  logic signed [W-1:0]  x4_d, z4_d, x4_q, z4_q;
  logic                 clip4_q;

  always_comb begin
    nx = 65'(xc_q) - 65'(zs_q);
    nz = 65'(xsn_q) + 65'(zc_q);
    if (cfg_i.corr_lvl >= dpc_pkg::LVL_ROTATE) begin
      xr = rot_round(nx);
      zr = rot_round(nz);
    end else begin
      xr = RW'(x3_q);
      zr = RW'(z3_q);
    end
    if (cfg_i.corr_lvl >= dpc_pkg::LVL_SLIDE) begin
      xr = xr + RW'(dpc_pkg::SLIDE_X);
      zr = zr + RW'(dpc_pkg::SLIDE_Z);
    end
    if (xr > SAT)       x4_d = W'(SAT);
    else if (xr < -SAT) x4_d = W'(-SAT);
    else                x4_d = W'(xr);
    if (zr > SAT)       z4_d = W'(SAT);
    else if (zr < -SAT) z4_d = W'(-SAT);
    else                z4_d = W'(zr);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x4_q    <= x4_d;
      z4_q    <= z4_d;
      clip4_q <= clip3_q;
    end
  end

  assign x_o    = x4_q;
  assign z_o    = z4_q;
  assign clip_o = clip4_q;

endmodule

@@ design/dpc_seg.sv @@
module dpc_seg #(
  parameter dpc_pkg::map_e MAP = dpc_pkg::MAP_COARSE_X
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic                               apply_i,
  input  logic signed [dpc_pkg::WORK_W-1:0]  v_i,
  output logic signed [dpc_pkg::WORK_W-1:0]  v_o
);

  localparam int W    = dpc_pkg::WORK_W;
  localparam int NB   = dpc_pkg::nbrk(MAP);
  localparam bit STR  = dpc_pkg::is_stretch(MAP);
  localparam bit LOWC = dpc_pkg::lower_closed(MAP);
  localparam int IW   = dpc_pkg::SEG_IDX_W;
  localparam int MW   = dpc_pkg::M_W;
  localparam int QW   = dpc_pkg::Q_W;
  localparam int UW   = dpc_pkg::MUL_W;
  localparam int DW   = dpc_pkg::DIV_W;
  localparam int RCW  = dpc_pkg::RECIP_W;

  // Per-segment constant tables
  logic signed [W-1:0] start_tab [dpc_pkg::MAX_BRK];
  logic signed [W-1:0] base_tab  [dpc_pkg::MAX_BRK];
  logic [UW-1:0]       mul_tab   [dpc_pkg::MAX_BRK];
  logic [DW-1:0]       div_tab   [dpc_pkg::MAX_BRK];
  logic [RCW-1:0]      recip_tab [dpc_pkg::MAX_BRK];

  for (genvar g = 0; g < dpc_pkg::MAX_BRK; g++) begin : g_tab
    localparam longint DV = dpc_pkg::seg_div(MAP, g);
    localparam longint RC = (64'sd1 <<< dpc_pkg::RECIP_SHIFT) / DV;
    assign start_tab[g] = W'(dpc_pkg::seg_start(MAP, g));
    assign base_tab[g]  = W'(dpc_pkg::seg_base(MAP, g));
    assign mul_tab[g]   = UW'(dpc_pkg::seg_mul(MAP, g));
    assign div_tab[g]   = DW'(DV);
    assign recip_tab[g] = RCW'(RC);
  end

  // Stage A: segment select and distance from segment start
  logic [IW-1:0]       seg_d, a_seg_q;
  logic                in_rng;
  logic signed [W:0]   diff;
  logic                a_neg_d, a_neg_q, a_byp_q;
  logic [W-1:0]        a_mag_d, a_mag_q;
  logic signed [W-1:0] a_v_q;

  always_comb begin
    logic [IW-1:0] cnt;
    logic          hit;
    cnt = '0;
    hit = 1'b0;
    for (int j = 1; j < dpc_pkg::MAX_BRK - 1; j++) begin
      if (j <= NB - 2) begin
        hit = LOWC ? (v_i >= start_tab[j]) : (v_i > start_tab[j]);
        cnt = cnt + IW'(hit);
      end
    end
    if (STR) begin
      if (v_i < start_tab[0]) begin
        in_rng = 1'b1;
        seg_d  = '0;
      end else if (v_i > start_tab[1]) begin
        in_rng = 1'b1;
        seg_d  = IW'(1);
      end else begin
        in_rng = 1'b0;
        seg_d  = '0;
      end
    end else begin
      in_rng = (v_i > start_tab[0]) && (v_i <= start_tab[NB-1]);
      seg_d  = cnt;
    end
    diff    = (W+1)'(v_i) - (W+1)'(start_tab[seg_d]);
    a_neg_d = diff[W];
    a_mag_d = a_neg_d ? W'(-diff) : W'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_seg_q <= seg_d;
      a_neg_q <= a_neg_d;
      a_mag_q <= a_mag_d;
      a_byp_q <= !apply_i || !in_rng;
      a_v_q   <= v_i;
    end
  end

  // Stage B: distance times target span
  logic [W+UW-1:0]     prod_b;
  logic [MW-1:0]       b_p_q;
  logic [IW-1:0]       b_seg_q;
  logic                b_neg_q, b_byp_q;
  logic signed [W-1:0] b_v_q;

  assign prod_b = a_mag_q * mul_tab[a_seg_q];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_p_q   <= MW'(prod_b);
      b_seg_q <= a_seg_q;
      b_neg_q <= a_neg_q;
      b_byp_q <= a_byp_q;
      b_v_q   <= a_v_q;
    end
  end

  // Stage C: add half divisor, estimate quotient by reciprocal
  logic [MW-1:0]       m_c;
  logic [MW+RCW-1:0]   prod_c;
  logic [MW-1:0]       c_m_q;
  logic [QW-1:0]       c_q0_q;
  logic [IW-1:0]       c_seg_q;
  logic                c_neg_q, c_byp_q;
  logic signed [W-1:0] c_v_q;

  assign m_c    = b_p_q + MW'(div_tab[b_seg_q] >> 1);
  assign prod_c = m_c * recip_tab[b_seg_q];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_m_q   <= m_c;
      c_q0_q  <= QW'(prod_c >> dpc_pkg::RECIP_SHIFT);
      c_seg_q <= b_seg_q;
      c_neg_q <= b_neg_q;
      c_byp_q <= b_byp_q;
      c_v_q   <= b_v_q;
    end
  end

  // Stage D: quotient correction (estimate is exact or one low)
  logic [QW+DW-1:0]    prod_d;
  logic [MW-1:0]       rem_d;
  logic [QW-1:0]       q_d, d_q_q;
  logic [IW-1:0]       d_seg_q;
  logic                d_neg_q, d_byp_q;
  logic signed [W-1:0] d_v_q;

  assign prod_d = c_q0_q * div_tab[c_seg_q];
  assign rem_d  = c_m_q - MW'(prod_d);
  assign q_d    = (rem_d >= MW'(div_tab[c_seg_q])) ? c_q0_q + QW'(1) : c_q0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q_q   <= q_d;
      d_seg_q <= c_seg_q;
      d_neg_q <= c_neg_q;
      d_byp_q <= c_byp_q;
      d_v_q   <= c_v_q;
    end
  end

  // Stage E: add the signed quotient to the segment base, or pass the input through on bypass
  logic signed [QW:0]   qs;
  logic signed [QW+1:0] sum_e;
  logic signed [W-1:0]  e_v_q;

  assign qs    = $signed({1'b0, d_q_q});
  assign sum_e = d_neg_q ? (QW+2)'(base_tab[d_seg_q]) - (QW+2)'(qs)
                         : (QW+2)'(base_tab[d_seg_q]) + (QW+2)'(qs);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_v_q <= d_byp_q ? d_v_q : W'(sum_e);
    end
  end

  assign v_o = e_v_q;

endmodule

@@ design/detector_position_calibration.sv @@
// Delay-line position calibration. Each input transfer carries four timing
// counts; each output transfer carries the calibrated x/z position in 1/256 mm
// and a clipped flag. One event enters per clock while the skid register is
// free; there are 20 register stages (4 front stages for scaling and rotation,
// three 5-stage segment-map units for the coarse, fine and stretch corrections,
// and one output stage). A stall on the output first fills a one-entry skid
// register and then holds the whole pipeline, so nothing is lost or repeated.
// Configuration must be written over APB only while no event is in flight; the
// block itself does not enforce this. pready is always high.
module detector_position_calibration #(
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dpc_in_if.sink                      in_ch,
  dpc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int W    = dpc_pkg::WORK_W;
  localparam int OW   = dpc_pkg::OUT_W;
  localparam int SEGS = 3 * dpc_pkg::SEG_DEPTH;
  localparam int LAT  = dpc_pkg::FRONT_DEPTH + SEGS + 1;

  dpc_pkg::cfg_t cfg;
  logic          en;
  logic          skid_v_q;

  dpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline advances whenever the skid register is free
  assign en          = !skid_v_q;
  assign in_ch.ready = en;

  // Valid bits travel with the data
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_ch.valid};
    end
  end

  // Scaling, offset, rotation, slide
  logic signed [W-1:0] fx, fz;
  logic                fclip;

  dpc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .cfg_i      (cfg),
    .x_first_i  (in_ch.x_first_time),
    .x_second_i (in_ch.x_second_time),
    .z_first_i  (in_ch.z_first_time),
    .z_second_i (in_ch.z_second_time),
    .x_o        (fx),
    .z_o        (fz),
    .clip_o     (fclip)
  );

  // Piecewise corrections per axis
  logic signed [W-1:0] cx, cz, nx, nz, sx, sz;
  logic                ap_coarse, ap_fine, ap_stretch;

  assign ap_coarse  = cfg.corr_lvl >= dpc_pkg::LVL_COARSE;
  assign ap_fine    = cfg.corr_lvl >= dpc_pkg::LVL_FINE;
  assign ap_stretch = cfg.corr_lvl >= dpc_pkg::LVL_STRETCH;

  dpc_seg #(.MAP(dpc_pkg::MAP_COARSE_X)) u_coarse_x (
    .clk_i(clk_i), .en_i(en), .apply_i(ap_coarse), .v_i(fx), .v_o(cx));
  dpc_seg #(.MAP(dpc_pkg::MAP_COARSE_Z)) u_coarse_z (
    .clk_i(clk_i), .en_i(en), .apply_i(ap_coarse), .v_i(fz), .v_o(cz));
  dpc_seg #(.MAP(dpc_pkg::MAP_FINE_X)) u_fine_x (
    .clk_i(clk_i), .en_i(en), .apply_i(ap_fine), .v_i(cx), .v_o(nx));
  dpc_seg #(.MAP(dpc_pkg::MAP_FINE_Z)) u_fine_z (
    .clk_i(clk_i), .en_i(en), .apply_i(ap_fine), .v_i(cz), .v_o(nz));
  dpc_seg #(.MAP(dpc_pkg::MAP_STRETCH_X)) u_stretch_x (
    .clk_i(clk_i), .en_i(en), .apply_i(ap_stretch), .v_i(nx), .v_o(sx));
  dpc_seg #(.MAP(dpc_pkg::MAP_STRETCH_Z)) u_stretch_z (
    .clk_i(clk_i), .en_i(en), .apply_i(ap_stretch), .v_i(nz), .v_o(sz));

  // Clip flag delay alongside the segment units
  logic [SEGS-1:0] clip_line_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      clip_line_q <= {clip_line_q[SEGS-2:0], fclip};
    end
  end

  // Final stage: z sign, mismatch, output saturation
  logic signed [W:0]    gx, gz;
  logic signed [OW-1:0] ox_d, oz_d, res_x_q, res_z_q;
  logic                 oc_d, res_c_q;

  always_comb begin
    gx   = (W+1)'(sx);
    gz   = cfg.alt_geometry ? (W+1)'(sz) : -((W+1)'(sz));
    oc_d = clip_line_q[SEGS-1];
    if (cfg.corr_lvl >= dpc_pkg::LVL_MISMATCH && cfg.alt_geometry) begin
      gx = gx - (W+1)'(dpc_pkg::MISMATCH_X);
      gz = gz - (W+1)'(dpc_pkg::MISMATCH_Z);
    end
    if (gx > (W+1)'(dpc_pkg::OUT_MAX)) begin
      ox_d = OW'(dpc_pkg::OUT_MAX);
      oc_d = 1'b1;
    end else if (gx < (W+1)'(dpc_pkg::OUT_MIN)) begin
      ox_d = OW'(dpc_pkg::OUT_MIN);
      oc_d = 1'b1;
    end else begin
      ox_d = OW'(gx);
    end
    if (gz > (W+1)'(dpc_pkg::OUT_MAX)) begin
      oz_d = OW'(dpc_pkg::OUT_MAX);
      oc_d = 1'b1;
    end else if (gz < (W+1)'(dpc_pkg::OUT_MIN)) begin
      oz_d = OW'(dpc_pkg::OUT_MIN);
      oc_d = 1'b1;
    end else begin
      oz_d = OW'(gz);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_x_q <= ox_d;
      res_z_q <= oz_d;
      res_c_q <= oc_d;
    end
  end

  // Skid register: catches the result when the sink stalls
  logic signed [OW-1:0] skid_x_q, skid_z_q;
  logic                 skid_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ch.ready) skid_v_q <= 1'b0;
    end else if (vld_q[LAT-1] && !out_ch.ready) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_x_q <= res_x_q;
      skid_z_q <= res_z_q;
      skid_c_q <= res_c_q;
    end
  end

  assign out_ch.valid      = skid_v_q || vld_q[LAT-1];
  assign out_ch.x_position = skid_v_q ? skid_x_q : res_x_q;
  assign out_ch.z_position = skid_v_q ? skid_z_q : res_z_q;
  assign out_ch.clipped    = skid_v_q ? skid_c_q : res_c_q;

endmodule
